>>> rtl/led_strip_store_rotate_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// LED strip store assertion macros
// Shared forms of the concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_STORE_ROTATE_ENCODER_TOP_DEFINES_SVH
`define LED_STRIP_STORE_ROTATE_ENCODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEDSRE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEDSRE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`define LEDSRE_ASSERT_DLY3(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##3 (cons)) \
      else $error(msg);

`endif

>>> rtl/ledsre_pkg.sv
// ----------------------------------------------------------------------------
// LED strip store package
// Widths, command codes, register indexes and reset values of the block.
// ----------------------------------------------------------------------------
package ledsre_pkg;

   localparam int LED_COUNT_DEF = 16;
   localparam int IDX_W         = 4;
   localparam int CHAN_W        = 8;
   localparam int PIXEL_W       = 3 * CHAN_W;
   localparam int DUTY_W        = 8;
   localparam int MODE_W        = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int BITS_PER_LED  = PIXEL_W;
   localparam int PAUSE_SLOTS   = 8;
   localparam int CNT_W         = $clog2(BITS_PER_LED);

   localparam logic [DUTY_W-1:0] DUTY_ONE_RST  = DUTY_W'(60);
   localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = DUTY_W'(30);

   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_ONE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_ZERO = CSR_IDX_W'(1);

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE     = 2'd0,
      MODE_ROT_RIGHT = 2'd1,
      MODE_ROT_LEFT  = 2'd2,
      MODE_EMIT      = 2'd3
   } mode_type;

endpackage

>>> rtl/ledsre_ram.sv
// ----------------------------------------------------------------------------
// LED strip store RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ledsre_ram #(
   parameter int WIDTH = ledsre_pkg::PIXEL_W,
   parameter int DEPTH = ledsre_pkg::LED_COUNT_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/led_strip_store_rotate_encoder_top.sv
// ----------------------------------------------------------------------------
// LED strip colour store with rotate commands and bit encoder
// Holds one 24-bit colour per LED and turns a stored LED into timer duty codes.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A write leaves busy
// low. A rotate moves span entries one place (span is last - first for a
// forward range, zero otherwise); one entry moves per cycle through the
// single read and write port of the colour RAM. An emit shifts the stored
// colour out one bit per cycle: the colour is read, loaded into the shift
// register and each duty code is registered out, one code follows every
// cycle with no gaps, and busy falls as the final code of the run, or the
// last of the 8 pause slots that follow an emit of the last LED, is shown.
// Results are shown for one cycle on rsp_valid and cannot be held off, so
// the receiver must take every item as it comes. Commands naming an LED
// beyond the strip are dropped. The colour store reads as zero after reset
// without a clearing pass; duty registers may be written at any time the
// block is idle, and csr_ready is always high.
// ----------------------------------------------------------------------------
`include "led_strip_store_rotate_encoder_top_defines.svh"

module led_strip_store_rotate_encoder_top #(
   parameter int LED_COUNT = ledsre_pkg::LED_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ledsre_pkg::MODE_W-1:0]    req_mode,
   input  logic [ledsre_pkg::IDX_W-1:0]     req_first_index,
   input  logic [ledsre_pkg::IDX_W-1:0]     req_last_index,
   input  logic [ledsre_pkg::CHAN_W-1:0]    req_chan0_value,
   input  logic [ledsre_pkg::CHAN_W-1:0]    req_chan1_value,
   input  logic [ledsre_pkg::CHAN_W-1:0]    req_chan2_value,
   output logic                             rsp_valid,
   output logic [ledsre_pkg::DUTY_W-1:0]    rsp_duty_code,
   output logic                             rsp_last_of_run,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ledsre_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ledsre_pkg::DUTY_W-1:0]    csr_wdata
);

   localparam int ADDR_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int IDX_W   = ledsre_pkg::IDX_W;
   localparam int PIXEL_W = ledsre_pkg::PIXEL_W;
   localparam int DUTY_W  = ledsre_pkg::DUTY_W;
   localparam int CNT_W   = ledsre_pkg::CNT_W;

   typedef enum logic [2:0] {
      IDLE,
      KEEP_CAP,
      MOVE,
      PUT_KEEP,
      EMIT_LOAD,
      EMIT_BITS,
      PAUSE
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [IDX_W-1:0]     stop_ff, stop_in;
   logic                 dir_up_ff, dir_up_in;
   logic [PIXEL_W-1:0]   keep_ff, keep_in;
   logic [PIXEL_W-1:0]   shift_ff, shift_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pause_ff, pause_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]    rsp_duty_ff, rsp_duty_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [DUTY_W-1:0]    duty_one_ff, duty_one_in;
   logic [DUTY_W-1:0]    duty_zero_ff, duty_zero_in;
   logic [LED_COUNT-1:0] valid_ff, valid_in;
   logic                 rd_valid_ff, rd_valid_in;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [PIXEL_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [PIXEL_W-1:0]   ram_rd_data;
   logic [PIXEL_W-1:0]   rd_pixel;

   logic                 first_ok;
   logic                 last_ok;
   logic [IDX_W-1:0]     nb;
   logic [IDX_W-1:0]     nb2;
   logic                 more_at_ptr;
   logic                 more_at_nb;

   ledsre_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (LED_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // An entry never written since reset reads as black.
   assign rd_pixel = rd_valid_ff ? ram_rd_data : '0;

   assign first_ok = int'(req_first_index) < LED_COUNT;
   assign last_ok  = int'(req_last_index) < LED_COUNT;

   // Neighbours along the walk: downwards for rotate right, upwards for left.
   assign nb  = dir_up_ff ? IDX_W'(ptr_ff - 1'b1) : IDX_W'(ptr_ff + 1'b1);
   assign nb2 = dir_up_ff ? IDX_W'(nb - 1'b1) : IDX_W'(nb + 1'b1);
   assign more_at_ptr = dir_up_ff ? (ptr_ff > stop_ff) : (ptr_ff < stop_ff);
   assign more_at_nb  = dir_up_ff ? (nb > stop_ff) : (nb < stop_ff);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      stop_in      = stop_ff;
      dir_up_in    = dir_up_ff;
      keep_in      = keep_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      pause_in     = pause_ff;
      rsp_valid_in = 1'b0;
      rsp_duty_in  = '0;
      rsp_last_in  = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               unique case (ledsre_pkg::mode_type'(req_mode))
                  ledsre_pkg::MODE_WRITE: begin
                     if (first_ok) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ADDR_W'(req_first_index);
                        ram_wr_data = {req_chan0_value, req_chan1_value, req_chan2_value};
                     end
                  end
                  ledsre_pkg::MODE_ROT_RIGHT: begin
                     if (first_ok && last_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(req_last_index);
                        ptr_in      = req_last_index;
                        stop_in     = req_first_index;
                        dir_up_in   = 1'b1;
                        state_in    = KEEP_CAP;
                     end
                  end
                  ledsre_pkg::MODE_ROT_LEFT: begin
                     if (first_ok && last_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(req_first_index);
                        ptr_in      = req_first_index;
                        stop_in     = req_last_index;
                        dir_up_in   = 1'b0;
                        state_in    = KEEP_CAP;
                     end
                  end
                  ledsre_pkg::MODE_EMIT: begin
                     if (first_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(req_first_index);
                        pause_in    = int'(req_first_index) == LED_COUNT - 1;
                        state_in    = EMIT_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         KEEP_CAP: begin
            // The entry that wraps round is held until the others have moved.
            keep_in = rd_pixel;
            if (more_at_ptr) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(nb);
               state_in    = MOVE;
            end else begin
               state_in = PUT_KEEP;
            end
         end
         MOVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(ptr_ff);
            ram_wr_data = rd_pixel;
            ptr_in      = nb;
            if (more_at_nb) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(nb2);
            end else begin
               state_in = PUT_KEEP;
            end
         end
         PUT_KEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(stop_ff);
            ram_wr_data = keep_ff;
            state_in    = IDLE;
         end
         EMIT_LOAD: begin
            shift_in = rd_pixel;
            cnt_in   = '0;
            state_in = EMIT_BITS;
         end
         EMIT_BITS: begin
            rsp_valid_in = 1'b1;
            rsp_duty_in  = shift_ff[PIXEL_W-1] ? duty_one_ff : duty_zero_ff;
            shift_in     = {shift_ff[PIXEL_W-2:0], 1'b0};
            cnt_in       = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(ledsre_pkg::BITS_PER_LED - 1)) begin
               cnt_in      = '0;
               rsp_last_in = !pause_ff;
               state_in    = pause_ff ? PAUSE : IDLE;
            end
         end
         PAUSE: begin
            rsp_valid_in = 1'b1;
            cnt_in       = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(ledsre_pkg::PAUSE_SLOTS - 1)) begin
               rsp_last_in = 1'b1;
               state_in    = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
      rd_valid_in = ram_rd_en ? valid_ff[ram_rd_addr] : rd_valid_ff;
   end

   always_comb begin
      duty_one_in  = duty_one_ff;
      duty_zero_in = duty_zero_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ledsre_pkg::CSR_DUTY_ONE:  duty_one_in  = csr_wdata;
            ledsre_pkg::CSR_DUTY_ZERO: duty_zero_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         duty_one_ff  <= ledsre_pkg::DUTY_ONE_RST;
         duty_zero_ff <= ledsre_pkg::DUTY_ZERO_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= rd_valid_in;
         duty_one_ff  <= duty_one_in;
         duty_zero_ff <= duty_zero_in;
      end
      ptr_ff      <= ptr_in;
      stop_ff     <= stop_in;
      dir_up_ff   <= dir_up_in;
      keep_ff     <= keep_in;
      shift_ff    <= shift_in;
      cnt_ff      <= cnt_in;
      pause_ff    <= pause_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy            = state_ff != IDLE;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_code   = rsp_duty_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `LEDSRE_ASSERT_NEXT(a_run_unbroken, rsp_valid && !rsp_last_of_run, rsp_valid,
      "duty code run broke off before its final item")

   `LEDSRE_ASSERT_SAME(a_busy_during_run, rsp_valid && !rsp_last_of_run, busy,
      "block went idle while a duty code run was still going")

   `LEDSRE_ASSERT_DLY3(a_emit_latency,
      start && !busy && (req_mode == ledsre_pkg::MODE_EMIT) && (int'(req_first_index) < LED_COUNT),
      rsp_valid, "emit command did not give its first duty code on time")

endmodule

>>> sim/led_strip_store_rotate_encoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED strip store testbench
// Drives write, rotate and emit commands through the start/busy port and
// checks every duty code against a scoreboard that keeps its own colour store,
// across several duty register settings and sender idling patterns.
// ----------------------------------------------------------------------------
module led_strip_store_rotate_encoder_top_tb;

   localparam int LED_COUNT_DEF = ledsre_pkg::LED_COUNT_DEF;
   localparam int IDX_W         = ledsre_pkg::IDX_W;
   localparam int CHAN_W        = ledsre_pkg::CHAN_W;
   localparam int PIXEL_W       = ledsre_pkg::PIXEL_W;
   localparam int DUTY_W        = ledsre_pkg::DUTY_W;
   localparam int MODE_W        = ledsre_pkg::MODE_W;
   localparam int CSR_IDX_W     = ledsre_pkg::CSR_IDX_W;
   localparam int BITS_PER_LED  = ledsre_pkg::BITS_PER_LED;
   localparam int PAUSE_SLOTS   = ledsre_pkg::PAUSE_SLOTS;

   // Register indexes beyond the list; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_0 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_1 = CSR_IDX_W'(3);

   localparam int QUIET_LIMIT  = 500;
   localparam int SETTLE_WAIT  = 40;
   localparam int ITEMS_PHASE  = 50;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              final_slot;
   } duty_slot_type;

   class strip_scoreboard_type;
      logic [PIXEL_W-1:0] colours [LED_COUNT_DEF];
      logic [DUTY_W-1:0]  duty_one;
      logic [DUTY_W-1:0]  duty_zero;
      duty_slot_type      pending_slots [$];
      int unsigned        fail_count;

      function new();
         foreach (colours[i]) colours[i] = '0;
         duty_one   = ledsre_pkg::DUTY_ONE_RST;
         duty_zero  = ledsre_pkg::DUTY_ZERO_RST;
         fail_count = 0;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         fail_count++;
      endtask

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [DUTY_W-1:0] data);
         if (idx == ledsre_pkg::CSR_DUTY_ONE) begin
            duty_one = data;
         end else if (idx == ledsre_pkg::CSR_DUTY_ZERO) begin
            duty_zero = data;
         end
      endfunction

      function void note_command(ledsre_pkg::mode_type m, logic [IDX_W-1:0] lo,
                                 logic [IDX_W-1:0] hi,
                                 logic [CHAN_W-1:0] c0, logic [CHAN_W-1:0] c1,
                                 logic [CHAN_W-1:0] c2);
         logic [PIXEL_W-1:0] keep;
         logic [PIXEL_W-1:0] colour;
         duty_slot_type      slot;
         int                 n;
         if (int'(lo) >= LED_COUNT_DEF) return;
         unique case (m)
            ledsre_pkg::MODE_WRITE: begin
               colours[lo] = {c0, c1, c2};
            end
            ledsre_pkg::MODE_ROT_RIGHT: begin
               if (int'(hi) < LED_COUNT_DEF) begin
                  // A reversed range leaves the loop empty, so only one copy is made.
                  keep = colours[hi];
                  for (int i = hi; i > lo; i--) colours[i] = colours[i-1];
                  colours[lo] = keep;
               end
            end
            ledsre_pkg::MODE_ROT_LEFT: begin
               if (int'(hi) < LED_COUNT_DEF) begin
                  keep = colours[lo];
                  for (int i = lo; i < hi; i++) colours[i] = colours[i+1];
                  colours[hi] = keep;
               end
            end
            ledsre_pkg::MODE_EMIT: begin
               colour = colours[lo];
               n = (int'(lo) == LED_COUNT_DEF - 1) ? BITS_PER_LED + PAUSE_SLOTS : BITS_PER_LED;
               for (int s = 0; s < n; s++) begin
                  if (s < BITS_PER_LED) begin
                     slot.duty = colour[BITS_PER_LED-1-s] ? duty_one : duty_zero;
                  end else begin
                     slot.duty = '0;
                  end
                  slot.final_slot = (s == n - 1);
                  pending_slots.push_back(slot);
               end
            end
            default: ;
         endcase
      endfunction

      task check_slot(logic [DUTY_W-1:0] duty, logic final_slot);
         duty_slot_type want;
         if (pending_slots.size() == 0) begin
            report_mismatch($sformatf("duty code %0d with nothing pending", duty));
            return;
         end
         want = pending_slots.pop_front();
         if (duty !== want.duty) begin
            report_mismatch($sformatf("duty code %0d, wanted %0d", duty, want.duty));
         end
         if (final_slot !== want.final_slot) begin
            report_mismatch($sformatf("last_of_run %0b, wanted %0b",
                                      final_slot, want.final_slot));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [MODE_W-1:0]    req_mode = '0;
   logic [IDX_W-1:0]     req_first_index = '0;
   logic [IDX_W-1:0]     req_last_index = '0;
   logic [CHAN_W-1:0]    req_chan0_value = '0;
   logic [CHAN_W-1:0]    req_chan1_value = '0;
   logic [CHAN_W-1:0]    req_chan2_value = '0;
   logic                 rsp_valid;
   logic [DUTY_W-1:0]    rsp_duty_code;
   logic                 rsp_last_of_run;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DUTY_W-1:0]    csr_wdata = '0;

   strip_scoreboard_type sb = new();
   int                   quiet_cycles = 0;

   led_strip_store_rotate_encoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_chan0_value (req_chan0_value),
      .req_chan1_value (req_chan1_value),
      .req_chan2_value (req_chan2_value),
      .rsp_valid       (rsp_valid),
      .rsp_duty_code   (rsp_duty_code),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // Results are checked before the item of the same edge is noted; the
   // block cannot answer an item in the cycle that takes it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_slot(rsp_duty_code, rsp_last_of_run);
         if (start && !busy) begin
            sb.note_command(ledsre_pkg::mode_type'(req_mode), req_first_index,
                            req_last_index, req_chan0_value, req_chan1_value,
                            req_chan2_value);
         end
         if (csr_valid && csr_ready) sb.set_register(csr_index, csr_wdata);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task send_command(ledsre_pkg::mode_type m, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                     logic [CHAN_W-1:0] c0, logic [CHAN_W-1:0] c1, logic [CHAN_W-1:0] c2);
      start           <= 1'b1;
      req_mode        <= m;
      req_first_index <= lo;
      req_last_index  <= hi;
      req_chan0_value <= c0;
      req_chan1_value <= c1;
      req_chan2_value <= c2;
      do @(posedge clock); while (busy);
   endtask

   // Fields carry noise while start is low; the block must not take it.
   task hold_off(int cycles);
      start           <= 1'b0;
      req_mode        <= MODE_W'($urandom);
      req_first_index <= IDX_W'($urandom);
      req_chan0_value <= CHAN_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task drain_results();
      start <= 1'b0;
      while (sb.pending_slots.size() != 0) @(posedge clock);
      // A rotate gives no result, so allow its longest walk to finish.
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task program_register(logic [CSR_IDX_W-1:0] idx, logic [DUTY_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task random_command();
      int                   pick;
      ledsre_pkg::mode_type m;
      pick = $urandom_range(99);
      if (pick < 35) begin
         m = ledsre_pkg::MODE_WRITE;
      end else if (pick < 50) begin
         m = ledsre_pkg::MODE_ROT_RIGHT;
      end else if (pick < 65) begin
         m = ledsre_pkg::MODE_ROT_LEFT;
      end else begin
         m = ledsre_pkg::MODE_EMIT;
      end
      send_command(m, IDX_W'($urandom), IDX_W'($urandom), CHAN_W'($urandom),
                   CHAN_W'($urandom), CHAN_W'($urandom));
   endtask

   task random_phase(int count, int idle_pct);
      for (int k = 0; k < count; k++) begin
         random_command();
         if (k == count / 2) begin
            drain_results();
         end else if ($urandom_range(99) < idle_pct) begin
            hold_off($urandom_range(1, 30));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands at the reset duty values.
      send_command(ledsre_pkg::MODE_EMIT, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_EMIT, 4'd15, 4'd15, 8'hff, 8'hff, 8'hff);
      send_command(ledsre_pkg::MODE_WRITE, 4'd0, 4'd15, 8'hff, 8'hff, 8'hff);
      send_command(ledsre_pkg::MODE_WRITE, 4'd15, 4'd0, 8'ha5, 8'h5a, 8'h81);
      send_command(ledsre_pkg::MODE_WRITE, 4'd1, 4'd9, 8'h01, 8'h80, 8'h7e);
      send_command(ledsre_pkg::MODE_WRITE, 4'd2, 4'd3, 8'h12, 8'h34, 8'h56);
      send_command(ledsre_pkg::MODE_EMIT, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_EMIT, 4'd15, 4'd0, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_ROT_RIGHT, 4'd0, 4'd15, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_EMIT, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_EMIT, 4'd1, 4'd0, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_ROT_LEFT, 4'd0, 4'd15, 8'hff, 8'hff, 8'hff);
      send_command(ledsre_pkg::MODE_EMIT, 4'd15, 4'd15, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_ROT_RIGHT, 4'd5, 4'd5, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_ROT_LEFT, 4'd3, 4'd3, 8'h00, 8'h00, 8'h00);
      // Reversed ranges only copy one entry across.
      send_command(ledsre_pkg::MODE_ROT_RIGHT, 4'd12, 4'd1, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_EMIT, 4'd12, 4'd0, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_ROT_LEFT, 4'd14, 4'd2, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_EMIT, 4'd2, 4'd0, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_ROT_RIGHT, 4'd2, 4'd4, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_EMIT, 4'd3, 4'd0, 8'h00, 8'h00, 8'h00);
      send_command(ledsre_pkg::MODE_WRITE, 4'd15, 4'd0, 8'hff, 8'hff, 8'hff);
      send_command(ledsre_pkg::MODE_EMIT, 4'd15, 4'd0, 8'h00, 8'h00, 8'h00);
      drain_results();

      program_register(ledsre_pkg::CSR_DUTY_ONE, 8'hff);
      program_register(ledsre_pkg::CSR_DUTY_ZERO, 8'h00);
      random_phase(ITEMS_PHASE, 0);
      drain_results();

      // Indexes beyond the register list must be ignored.
      program_register(ledsre_pkg::CSR_DUTY_ONE, 8'h00);
      program_register(ledsre_pkg::CSR_DUTY_ZERO, 8'hff);
      program_register(CSR_SPARE_0, DUTY_W'($urandom));
      program_register(CSR_SPARE_1, DUTY_W'($urandom));
      random_phase(ITEMS_PHASE, 82);
      drain_results();

      program_register(ledsre_pkg::CSR_DUTY_ONE, DUTY_W'($urandom));
      program_register(ledsre_pkg::CSR_DUTY_ZERO, DUTY_W'($urandom));
      random_phase(ITEMS_PHASE, 9);
      drain_results();

      program_register(ledsre_pkg::CSR_DUTY_ZERO, DUTY_W'($urandom));
      program_register(ledsre_pkg::CSR_DUTY_ONE, DUTY_W'($urandom));
      random_phase(ITEMS_PHASE, 0);
      drain_results();

      if (sb.fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/ledsre_pkg.sv
rtl/ledsre_ram.sv
rtl/led_strip_store_rotate_encoder_top.sv
sim/led_strip_store_rotate_encoder_top_tb.sv
